>>> rtl/core/stmd_pkg.sv
// Shared types and constants for the stick to pointer delta pipeline.
`timescale 1ns / 1ps
`default_nettype none
package stmd_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_DEAD_ZONE   = 3'd0;
	localparam logic [2:0] REG_FULL_SCALE  = 3'd1;
	localparam logic [2:0] REG_CURVE_SEL   = 3'd2;
	localparam logic [2:0] REG_SENS_PCT    = 3'd3;
	localparam logic [2:0] REG_TOP_SPEED   = 3'd4;

	// Register reset values.
	localparam logic [15:0] RST_DEAD_ZONE  = 16'd4000;
	localparam logic [15:0] RST_FULL_SCALE = 16'd32000;
	localparam logic [7:0]  RST_CURVE_SEL  = 8'd2;
	localparam logic [6:0]  RST_SENS_PCT   = 7'd50;
	localparam logic [7:0]  RST_TOP_SPEED  = 8'd20;

	// Response curve codes; every other code is linear.
	localparam logic [7:0] CURVE_SQUARE = 8'd2;
	localparam logic [7:0] CURVE_SMOOTH = 8'd3;

	// Full scale of the normalized deflection.
	localparam logic [13:0] UNIT_SCALE = 14'd10000;

	// Floor division by 10000 as a multiply by ceil(2^40 / 10000) and a shift.
	localparam logic [26:0] RECIP_UNIT = 27'd109951163;

	// Floor division by 10000 * 100 as a multiply by ceil(2^50 / 1e6) and a shift.
	localparam logic [30:0] RECIP_SPEED = 31'd1125899907;

	localparam logic [7:0] SPEED_MAX = 8'd255;

	// Quotient bits of the two long dividers.
	localparam int NORM_BITS  = 14;
	localparam int SHARE_BITS = 8;

	// Per item information that rides along the whole pipeline.
	typedef struct packed {
		logic        zero;
		logic        x_neg;
		logic        x_pos;
		logic        y_pos;
		logic        ax_gt;
		logic [15:0] major;
		logic [15:0] minor;
	} side_t;

	// One stage of the normalizing divider.
	typedef struct packed {
		logic [15:0]          rem;
		logic [NORM_BITS-1:0] lo;
		logic [NORM_BITS-1:0] quo;
		logic [15:0]          den;
	} ndiv_t;

	// One stage of the minor axis share divider.
	typedef struct packed {
		logic [15:0]           rem;
		logic [SHARE_BITS-1:0] lo;
		logic [SHARE_BITS-1:0] quo;
		logic [7:0]            speed;
	} sdiv_t;

endpackage
`default_nettype wire

>>> rtl/core/stick_to_mouse_delta.sv
// Top level of the stick to pointer delta pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Turns one signed stick sample per word into one pointer delta word. The datapath is a
// 36 stage pipeline: a word is accepted in every cycle while the output is free or taken.
// The depth is set by the two restoring dividers, one quotient bit per stage: 14 stages
// for the normalized deflection and 8 stages for the minor axis share. Reciprocal
// multipliers do the constant divides. A stalled output holds the whole pipeline.
// Configuration writes are taken in every cycle and must be made while the pipeline
// is empty.
module stick_to_mouse_delta
	import stmd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input samples.
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] stick_x, [31:16] stick_y
	// Output deltas.
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,   // [8:0] move_x, [17:9] move_y, [23:18] zero
	// Configuration writes.
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int LAT = 36;

	logic        adv;
	logic [LAT:1] vld_s;

	logic [15:0] dead_zone_q;
	logic [15:0] full_scale_q;
	logic [7:0]  curve_sel_q;
	logic [6:0]  sens_pct_q;
	logic [7:0]  top_speed_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q  <= RST_DEAD_ZONE;
			full_scale_q <= RST_FULL_SCALE;
			curve_sel_q  <= RST_CURVE_SEL;
			sens_pct_q   <= RST_SENS_PCT;
			top_speed_q  <= RST_TOP_SPEED;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEAD_ZONE:  dead_zone_q  <= cfg_data;
				REG_FULL_SCALE: full_scale_q <= cfg_data;
				REG_CURVE_SEL:  curve_sel_q  <= cfg_data[7:0];
				REG_SENS_PCT:   sens_pct_q   <= cfg_data[6:0];
				REG_TOP_SPEED:  top_speed_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished word waits at the output.
	assign adv      = !vld_s[LAT] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	// Stage 1: absolute values and signs.
	logic [15:0] sx, sy;
	logic [15:0] ax_s1, ay_s1;
	logic        x_neg_s1, x_pos_s1, y_pos_s1;

	assign sx = s_tdata[15:0];
	assign sy = s_tdata[31:16];

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1    <= sx[15] ? 16'(-sx) : sx;
			ay_s1    <= sy[15] ? 16'(-sy) : sy;
			x_neg_s1 <= sx[15];
			x_pos_s1 <= !sx[15] && (sx != 16'd0);
			y_pos_s1 <= !sy[15] && (sy != 16'd0);
		end
	end

	// Stage 2: magnitude, dead zone test, clamp and divider operands.
	side_t       side_s [2:LAT-1];
	side_t       side_d;
	logic [15:0] clamp_m;
	logic [15:0] diff_s2, den_s2;

	always_comb begin
		side_d.ax_gt = ax_s1 > ay_s1;
		side_d.major = side_d.ax_gt ? ax_s1 : ay_s1;
		side_d.minor = side_d.ax_gt ? ay_s1 : ax_s1;
		side_d.zero  = (side_d.major < dead_zone_q) || (full_scale_q <= dead_zone_q);
		side_d.x_neg = x_neg_s1;
		side_d.x_pos = x_pos_s1;
		side_d.y_pos = y_pos_s1;
		clamp_m      = (side_d.major > full_scale_q) ? full_scale_q : side_d.major;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[2] <= side_d;
			diff_s2   <= clamp_m - dead_zone_q;
			den_s2    <= full_scale_q - dead_zone_q;
		end
	end

	// The item information follows its data down the line.
	for (genvar gp = 3; gp < LAT; gp++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[gp] <= side_s[gp-1];
			end
		end
	end

	// Stage 3: scale the deflection by 10000 and seed the normalizing divider.
	ndiv_t       ndv_s [0:NORM_BITS];
	logic [29:0] num1;

	assign num1 = 30'(diff_s2) * 30'(UNIT_SCALE);

	always_ff @(posedge clk) begin
		if (adv) begin
			ndv_s[0].rem <= num1[29:NORM_BITS];
			ndv_s[0].lo  <= num1[NORM_BITS-1:0];
			ndv_s[0].quo <= '0;
			ndv_s[0].den <= den_s2;
		end
	end

	// Stages 4 to 17: one quotient bit of the normalized deflection per stage.
	for (genvar gi = 0; gi < NORM_BITS; gi++) begin : g_ndiv
		localparam int BIT = NORM_BITS - 1 - gi;
		logic [16:0] r2;
		logic        ge;

		assign r2 = {ndv_s[gi].rem, ndv_s[gi].lo[BIT]};
		assign ge = r2 >= {1'b0, ndv_s[gi].den};

		always_ff @(posedge clk) begin
			if (adv) begin
				ndv_s[gi+1].rem <= ge ? 16'(r2 - {1'b0, ndv_s[gi].den}) : r2[15:0];
				ndv_s[gi+1].lo  <= ndv_s[gi].lo;
				ndv_s[gi+1].quo <= {ndv_s[gi].quo[NORM_BITS-2:0], ge};
				ndv_s[gi+1].den <= ndv_s[gi].den;
			end
		end
	end

	// Stages 18 to 21: square and cube terms, each divided by 10000.
	logic [13:0] n_s18, n_s19, n_s20, n_s21;
	logic [26:0] sq_s18, p3_s20;
	logic [13:0] t2_s19, t2_s20, t2_s21, t3_s21;
	logic [53:0] t2_prod, t3_prod;

	assign t2_prod = 54'(sq_s18) * 54'(RECIP_UNIT);
	assign t3_prod = 54'(p3_s20) * 54'(RECIP_UNIT);

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s18  <= ndv_s[NORM_BITS].quo;
			sq_s18 <= 27'(28'(ndv_s[NORM_BITS].quo) * 28'(ndv_s[NORM_BITS].quo));
			n_s19  <= n_s18;
			t2_s19 <= t2_prod[53:40];
			n_s20  <= n_s19;
			t2_s20 <= t2_s19;
			p3_s20 <= 27'(28'(t2_s19) * 28'(n_s19));
			n_s21  <= n_s20;
			t2_s21 <= t2_s20;
			t3_s21 <= t3_prod[53:40];
		end
	end

	// Stage 22: curve select. The cube term never exceeds the square term.
	logic [15:0] smooth;
	logic [13:0] c_d, c_s22;

	assign smooth = 16'(3 * 16'(t2_s21)) - 16'(2 * 16'(t3_s21));

	always_comb begin
		case (curve_sel_q)
			CURVE_SQUARE: c_d = t2_s21;
			CURVE_SMOOTH: c_d = (smooth > 16'(UNIT_SCALE)) ? UNIT_SCALE : smooth[13:0];
			default:      c_d = n_s21;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s22 <= c_d;
		end
	end

	// Stages 23 to 26: scale by sensitivity and top speed, divide by one million.
	logic [20:0] a_s23;
	logic [28:0] b_s24;
	logic [9:0]  q_s25;
	logic        cnz_s23, cnz_s24, cnz_s25;
	logic [7:0]  speed_s26;
	logic [59:0] q_prod;

	assign q_prod = 60'(b_s24) * 60'(RECIP_SPEED);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s23   <= 21'(c_s22) * 21'(sens_pct_q);
			cnz_s23 <= c_s22 != 14'd0;
			b_s24   <= 29'(a_s23) * 29'(top_speed_q);
			cnz_s24 <= cnz_s23;
			q_s25   <= q_prod[59:50];
			cnz_s25 <= cnz_s24;
			if (q_s25 == 10'd0 && cnz_s25) begin
				speed_s26 <= 8'd1;
			end else if (q_s25 > 10'(SPEED_MAX)) begin
				speed_s26 <= SPEED_MAX;
			end else begin
				speed_s26 <= q_s25[7:0];
			end
		end
	end

	// Stage 27: multiply speed by the minor axis and seed the share divider.
	sdiv_t       sdv_s [0:SHARE_BITS];
	logic [23:0] num2;

	assign num2 = 24'(speed_s26) * 24'(side_s[26].minor);

	always_ff @(posedge clk) begin
		if (adv) begin
			sdv_s[0].rem   <= num2[23:SHARE_BITS];
			sdv_s[0].lo    <= num2[SHARE_BITS-1:0];
			sdv_s[0].quo   <= '0;
			sdv_s[0].speed <= speed_s26;
		end
	end

	// Stages 28 to 35: one bit of the minor axis share per stage, over the major axis.
	for (genvar gj = 0; gj < SHARE_BITS; gj++) begin : g_sdiv
		localparam int BIT = SHARE_BITS - 1 - gj;
		logic [15:0] den;
		logic [16:0] r2;
		logic        ge;

		assign den = side_s[27+gj].major;
		assign r2  = {sdv_s[gj].rem, sdv_s[gj].lo[BIT]};
		assign ge  = r2 >= {1'b0, den};

		always_ff @(posedge clk) begin
			if (adv) begin
				sdv_s[gj+1].rem   <= ge ? 16'(r2 - {1'b0, den}) : r2[15:0];
				sdv_s[gj+1].lo    <= sdv_s[gj].lo;
				sdv_s[gj+1].quo   <= {sdv_s[gj].quo[SHARE_BITS-2:0], ge};
				sdv_s[gj+1].speed <= sdv_s[gj].speed;
			end
		end
	end

	// Stage 36: apply the signs and place speed on the dominant axis.
	side_t      sd;
	logic [8:0] spd9, shr9, dx_d, dy_d;
	logic [8:0] dx_s36, dy_s36;

	always_comb begin
		sd   = side_s[LAT-1];
		spd9 = {1'b0, sdv_s[SHARE_BITS].speed};
		shr9 = (sd.major == 16'd0) ? 9'd0 : {1'b0, sdv_s[SHARE_BITS].quo};
		if (sd.zero) begin
			dx_d = 9'd0;
			dy_d = 9'd0;
		end else if (sd.ax_gt) begin
			dx_d = sd.x_pos ? spd9 : 9'(-spd9);
			dy_d = sd.y_pos ? 9'(-shr9) : shr9;
		end else begin
			dy_d = sd.y_pos ? 9'(-spd9) : spd9;
			dx_d = sd.x_neg ? 9'(-shr9) : shr9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s36 <= dx_d;
			dy_s36 <= dy_d;
		end
	end

	assign m_tdata = {6'd0, dy_s36, dx_s36};

endmodule
`default_nettype wire

>>> rtl/core/stmd_check.sv
// Port checker for the stick to pointer delta pipeline and its bind.
`timescale 1ns / 1ps
`default_nettype none
module stmd_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// A stalled output word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("output word changed while stalled");

	// The input side is open whenever the output holds nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
	else $error("input blocked with an empty output");

	// Deltas stay within -255..255 on both axes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[8:0] != 9'h100 && m_tdata[17:9] != 9'h100)
	else $error("delta out of range");

	// Padding bits of the output word are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:18] == 6'd0)
	else $error("output padding not zero");

endmodule

bind stick_to_mouse_delta stmd_check u_stmd_check (.*);
`default_nettype wire
